@@ sv/barc_pkg.sv @@
// Shared types and constants for the barometer raw-sample compensation pipeline.
`default_nettype none

package barc_pkg;

	localparam int unsigned DIV_STEPS = 64;

	localparam logic signed [32:0] FINE_OFS   = 33'sd128000;
	localparam logic [63:0]        V1_BIAS    = 64'h0000_8000_0000_0000;
	localparam logic [20:0]        P_FULL     = 21'd1048576;
	localparam logic [11:0]        K_SCALE    = 12'd3125;
	localparam logic [31:0]        K_SCALE_32 = 32'd3125;

	typedef enum logic [1:0] {
		CFG_TEMP    = 2'd0,
		CFG_PRESS_A = 2'd1,
		CFG_PRESS_B = 2'd2,
		CFG_PRESS_C = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] temp;
		logic signed [31:0] tf;
		logic               pv;
		logic               neg;
		logic [63:0]        d;
		logic [63:0]        r;
		logic [63:0]        qd;
	} div_t;

endpackage

`default_nettype wire

@@ sv/barometer_raw_compensation.sv @@
// Top level: pipelined barometer raw-sample compensation with 64-bit divider.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one raw temperature and one
//    raw pressure sample per beat. Output channel (out_valid / out_stall)
//    returns temperature in 0.01 degC, fine temperature, pressure in Q24.8 Pa
//    and a flag that is low when the pressure divisor was zero.
//  - Calibration is written via cfg_valid/cfg_ready/cfg_index/cfg_data (always
//    ready); the user must keep this to an empty pipeline, the block does not.
//  - An accepted input beat passes through 13 stages of calibration maths,
//    64 stages of the restoring divider (one quotient bit per stage), 6
//    post-division stages and the output register. Throughput is one beat
//    per cycle while out_stall does not hold the output beat.
//  - The whole pipeline advances together; when the output beat is held by
//    out_stall, every stage holds and in_stall is raised in the same cycle.
//  - Reset clears all valid bits and the calibration registers to zero.
`default_nettype none

module barometer_raw_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [19:0] raw_pressure,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      temperature_centi,
	output logic [31:0]      fine_temperature,
	output logic [31:0]      pressure_q24_8,
	output logic             pressure_valid,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic en;

	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [15:0] cal_press_c_q;

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0]        p6_32, p3_32, p8_32, p9_32;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q    <= '0;
			cal_press_a_q <= '0;
			cal_press_b_q <= '0;
			cal_press_c_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (barc_pkg::cfg_reg_t'(cfg_index))
				barc_pkg::CFG_TEMP:    cal_temp_q    <= cfg_data[47:0];
				barc_pkg::CFG_PRESS_A: cal_press_a_q <= cfg_data;
				barc_pkg::CFG_PRESS_B: cal_press_b_q <= cfg_data;
				barc_pkg::CFG_PRESS_C: cal_press_c_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign t1 = cal_temp_q[15:0];
	assign t2 = $signed(cal_temp_q[31:16]);
	assign t3 = $signed(cal_temp_q[47:32]);
	assign p1 = cal_press_a_q[15:0];
	assign p2 = $signed(cal_press_a_q[31:16]);
	assign p3 = $signed(cal_press_a_q[47:32]);
	assign p4 = $signed(cal_press_a_q[63:48]);
	assign p5 = $signed(cal_press_b_q[15:0]);
	assign p6 = $signed(cal_press_b_q[31:16]);
	assign p7 = $signed(cal_press_b_q[47:32]);
	assign p8 = $signed(cal_press_b_q[63:48]);
	assign p9 = $signed(cal_press_c_q);
	assign p6_32 = {{16{p6[15]}}, p6};
	assign p3_32 = {{16{p3[15]}}, p3};
	assign p8_32 = {{16{p8[15]}}, p8};
	assign p9_32 = {{16{p9[15]}}, p9};

	// ---------------- flow control ----------------
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12;
	logic vld_p1, vld_p2, vld_p3, vld_p4, vld_p5, vld_p6;
	logic div_v_s [0:barc_pkg::DIV_STEPS];

	// ---------------- temperature path ----------------
	logic signed [18:0] a_s1;
	logic signed [17:0] b_s1;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8, rp_s9;

	logic signed [34:0] m1_w;
	logic signed [35:0] bb_w;
	logic signed [34:0] m1_s2;
	logic [31:0]        bb_s2;

	logic signed [31:0] m1_lo, v1t_w, bbs_w;
	logic signed [47:0] m3_w;
	logic signed [31:0] v1t_s3;
	logic [31:0]        m3_s3;

	logic signed [31:0] v2t_w;
	logic signed [31:0] tf_s4;

	logic signed [31:0] t5_sum, temp_w;
	logic signed [31:0] temp_s5, tf_s5;
	logic signed [32:0] x_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= $signed({2'b00, raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
			b_s1  <= $signed({2'b00, raw_temperature[19:4]}) - $signed({2'b00, t1});
			rp_s1 <= raw_pressure;
		end
	end

	assign m1_w = a_s1 * t2;
	assign bb_w = b_s1 * b_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s2 <= m1_w;
			bb_s2 <= bb_w[31:0];
			rp_s2 <= rp_s1;
		end
	end

	assign m1_lo = m1_s2[31:0];
	assign v1t_w = m1_lo >>> 11;
	assign bbs_w = $signed(bb_s2) >>> 12;
	assign m3_w  = bbs_w * t3;

	always_ff @(posedge clk) begin
		if (en) begin
			v1t_s3 <= v1t_w;
			m3_s3  <= m3_w[31:0];
			rp_s3  <= rp_s2;
		end
	end

	assign v2t_w = $signed(m3_s3) >>> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			tf_s4 <= v1t_s3 + v2t_w;
			rp_s4 <= rp_s3;
		end
	end

	assign t5_sum = (tf_s4 <<< 2) + tf_s4 + 32'sd128;
	assign temp_w = t5_sum >>> 8;

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s5 <= temp_w;
			tf_s5   <= tf_s4;
			x_s5    <= $signed({tf_s4[31], tf_s4}) - barc_pkg::FINE_OFS;
			rp_s5   <= rp_s4;
		end
	end

	// ---------------- pressure path, before division ----------------
	logic signed [65:0] xx_w;
	logic signed [48:0] xp5_w, xp2_w;
	logic [63:0]        xx_s6;
	logic signed [48:0] xp5_s6, xp2_s6;
	logic signed [31:0] temp_s6, tf_s6;

	assign xx_w  = x_s5 * x_s5;
	assign xp5_w = x_s5 * p5;
	assign xp2_w = x_s5 * p2;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s6   <= xx_w[63:0];
			xp5_s6  <= xp5_w;
			xp2_s6  <= xp2_w;
			temp_s6 <= temp_s5;
			tf_s6   <= tf_s5;
			rp_s6   <= rp_s5;
		end
	end

	logic signed [48:0] xxp6l_w, xxp3l_w;
	logic [31:0]        xxp6h_w, xxp3h_w;
	logic signed [48:0] xxp6l_s7, xxp3l_s7, xp5_s7, xp2_s7;
	logic [31:0]        xxp6h_s7, xxp3h_s7;
	logic signed [31:0] temp_s7, tf_s7;

	assign xxp6l_w = $signed({1'b0, xx_s6[31:0]}) * p6;
	assign xxp3l_w = $signed({1'b0, xx_s6[31:0]}) * p3;
	assign xxp6h_w = xx_s6[63:32] * p6_32;
	assign xxp3h_w = xx_s6[63:32] * p3_32;

	always_ff @(posedge clk) begin
		if (en) begin
			xxp6l_s7 <= xxp6l_w;
			xxp3l_s7 <= xxp3l_w;
			xxp6h_s7 <= xxp6h_w;
			xxp3h_s7 <= xxp3h_w;
			xp5_s7   <= xp5_s6;
			xp2_s7   <= xp2_s6;
			temp_s7  <= temp_s6;
			tf_s7    <= tf_s6;
			rp_s7    <= rp_s6;
		end
	end

	logic [63:0]        xxp6_s8, xxp3_s8;
	logic signed [48:0] xp5_s8, xp2_s8;
	logic signed [31:0] temp_s8, tf_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			xxp6_s8 <= {{15{xxp6l_s7[48]}}, xxp6l_s7} + {xxp6h_s7, 32'h0};
			xxp3_s8 <= {{15{xxp3l_s7[48]}}, xxp3l_s7} + {xxp3h_s7, 32'h0};
			xp5_s8  <= xp5_s7;
			xp2_s8  <= xp2_s7;
			temp_s8 <= temp_s7;
			tf_s8   <= tf_s7;
			rp_s8   <= rp_s7;
		end
	end

	logic signed [63:0] xxp3_sh;
	logic [63:0]        v2_s9, v1a_s9;
	logic signed [31:0] temp_s9, tf_s9;

	assign xxp3_sh = $signed(xxp3_s8) >>> 8;

	always_ff @(posedge clk) begin
		if (en) begin
			v2_s9   <= xxp6_s8 + {xp5_s8[46:0], 17'h0}
				+ {{13{p4[15]}}, p4, 35'h0};
			v1a_s9  <= xxp3_sh + {{3{xp2_s8[48]}}, xp2_s8, 12'h0};
			temp_s9 <= temp_s8;
			tf_s9   <= tf_s8;
			rp_s9   <= rp_s8;
		end
	end

	logic [63:0]        v1b_w;
	logic [47:0]        v1pl_w;
	logic [31:0]        v1ph_w;
	logic [20:0]        pr_w;
	logic [47:0]        v1pl_s10;
	logic [31:0]        v1ph_s10;
	logic [63:0]        n0_s10;
	logic signed [31:0] temp_s10, tf_s10;

	assign v1b_w  = v1a_s9 + barc_pkg::V1_BIAS;
	assign v1pl_w = v1b_w[31:0] * p1;
	assign v1ph_w = v1b_w[63:32] * {16'h0, p1};
	assign pr_w   = barc_pkg::P_FULL - {1'b0, rp_s9};

	always_ff @(posedge clk) begin
		if (en) begin
			v1pl_s10 <= v1pl_w;
			v1ph_s10 <= v1ph_w;
			n0_s10   <= {12'h0, pr_w, 31'h0} - v2_s9;
			temp_s10 <= temp_s9;
			tf_s10   <= tf_s9;
		end
	end

	logic [63:0]        v1sum_w;
	logic signed [63:0] v1_w;
	logic [43:0]        nlo_w;
	logic [31:0]        nhi_w;
	logic [63:0]        v1_s11;
	logic [43:0]        nlo_s11;
	logic [31:0]        nhi_s11;
	logic signed [31:0] temp_s11, tf_s11;

	assign v1sum_w = {16'h0, v1pl_s10} + {v1ph_s10, 32'h0};
	assign v1_w    = $signed(v1sum_w) >>> 33;
	assign nlo_w   = n0_s10[31:0] * barc_pkg::K_SCALE;
	assign nhi_w   = n0_s10[63:32] * barc_pkg::K_SCALE_32;

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s11   <= v1_w;
			nlo_s11  <= nlo_w;
			nhi_s11  <= nhi_w;
			temp_s11 <= temp_s10;
			tf_s11   <= tf_s10;
		end
	end

	logic [63:0]        n_s12, v1_s12;
	logic signed [31:0] temp_s12, tf_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s12    <= {20'h0, nlo_s11} + {nhi_s11, 32'h0};
			v1_s12   <= v1_s11;
			temp_s12 <= temp_s11;
			tf_s12   <= tf_s11;
		end
	end

	// ---------------- restoring divider, one quotient bit a stage ----------------
	barc_pkg::div_t div_s [0:barc_pkg::DIV_STEPS];
	logic           nz_w;

	assign nz_w = (v1_s12 != 64'h0);

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].temp <= temp_s12;
			div_s[0].tf   <= tf_s12;
			div_s[0].pv   <= nz_w;
			div_s[0].neg  <= n_s12[63] ^ v1_s12[63];
			div_s[0].d    <= !nz_w ? 64'd1 : (v1_s12[63] ? (64'h0 - v1_s12) : v1_s12);
			div_s[0].r    <= 64'h0;
			div_s[0].qd   <= n_s12[63] ? (64'h0 - n_s12) : n_s12;
		end
	end

	for (genvar k = 0; k < barc_pkg::DIV_STEPS; k++) begin : g_div
		logic [63:0] trial;
		logic [64:0] diff;
		logic        ge;

		assign trial = {div_s[k].r[62:0], div_s[k].qd[63]};
		assign diff  = {1'b0, trial} - {1'b0, div_s[k].d};
		assign ge    = !diff[64];

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1].temp <= div_s[k].temp;
				div_s[k+1].tf   <= div_s[k].tf;
				div_s[k+1].pv   <= div_s[k].pv;
				div_s[k+1].neg  <= div_s[k].neg;
				div_s[k+1].d    <= div_s[k].d;
				div_s[k+1].r    <= ge ? diff[63:0] : trial;
				div_s[k+1].qd   <= {div_s[k].qd[62:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k+1] <= 1'b0;
			end else if (en) begin
				div_v_s[k+1] <= div_v_s[k];
			end
		end
	end

	// ---------------- pressure path, after division ----------------
	logic [63:0]        p_p1;
	logic               pv_p1;
	logic signed [31:0] temp_p1, tf_p1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_p1    <= div_s[barc_pkg::DIV_STEPS].neg ? (64'h0 - div_s[barc_pkg::DIV_STEPS].qd)
				: div_s[barc_pkg::DIV_STEPS].qd;
			pv_p1   <= div_s[barc_pkg::DIV_STEPS].pv;
			temp_p1 <= div_s[barc_pkg::DIV_STEPS].temp;
			tf_p1   <= div_s[barc_pkg::DIV_STEPS].tf;
		end
	end

	logic signed [63:0] ps_w;
	logic [63:0]        ll_w;
	logic [31:0]        cr_w, p8h_w;
	logic signed [48:0] p8l_w;
	logic [63:0]        ll_p2, p_p2;
	logic [31:0]        cr_p2, p8h_p2;
	logic signed [48:0] p8l_p2;
	logic               pv_p2;
	logic signed [31:0] temp_p2, tf_p2;

	assign ps_w  = $signed(p_p1) >>> 13;
	assign ll_w  = ps_w[31:0] * ps_w[31:0];
	assign cr_w  = ps_w[31:0] * ps_w[63:32];
	assign p8l_w = $signed({1'b0, p_p1[31:0]}) * p8;
	assign p8h_w = p_p1[63:32] * p8_32;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_p2   <= ll_w;
			cr_p2   <= cr_w;
			p8l_p2  <= p8l_w;
			p8h_p2  <= p8h_w;
			p_p2    <= p_p1;
			pv_p2   <= pv_p1;
			temp_p2 <= temp_p1;
			tf_p2   <= tf_p1;
		end
	end

	logic [63:0]        w2sum_w;
	logic signed [63:0] w2_w;
	logic [63:0]        sq_p3, w2_p3, p_p3;
	logic               pv_p3;
	logic signed [31:0] temp_p3, tf_p3;

	assign w2sum_w = {{15{p8l_p2[48]}}, p8l_p2} + {p8h_p2, 32'h0};
	assign w2_w    = $signed(w2sum_w) >>> 19;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_p3   <= ll_p2 + {cr_p2[30:0], 1'b0, 32'h0};
			w2_p3   <= w2_w;
			p_p3    <= p_p2;
			pv_p3   <= pv_p2;
			temp_p3 <= temp_p2;
			tf_p3   <= tf_p2;
		end
	end

	logic signed [48:0] p9l_w, p9l_p4;
	logic [31:0]        p9h_w, p9h_p4;
	logic [63:0]        w2_p4, p_p4;
	logic               pv_p4;
	logic signed [31:0] temp_p4, tf_p4;

	assign p9l_w = $signed({1'b0, sq_p3[31:0]}) * p9;
	assign p9h_w = sq_p3[63:32] * p9_32;

	always_ff @(posedge clk) begin
		if (en) begin
			p9l_p4  <= p9l_w;
			p9h_p4  <= p9h_w;
			w2_p4   <= w2_p3;
			p_p4    <= p_p3;
			pv_p4   <= pv_p3;
			temp_p4 <= temp_p3;
			tf_p4   <= tf_p3;
		end
	end

	logic [63:0]        w1sum_w;
	logic signed [63:0] w1_w;
	logic [63:0]        w1_p5, w2_p5, p_p5;
	logic               pv_p5;
	logic signed [31:0] temp_p5, tf_p5;

	assign w1sum_w = {{15{p9l_p4[48]}}, p9l_p4} + {p9h_p4, 32'h0};
	assign w1_w    = $signed(w1sum_w) >>> 25;

	always_ff @(posedge clk) begin
		if (en) begin
			w1_p5   <= w1_w;
			w2_p5   <= w2_p4;
			p_p5    <= p_p4;
			pv_p5   <= pv_p4;
			temp_p5 <= temp_p4;
			tf_p5   <= tf_p4;
		end
	end

	logic [63:0]        s_p6;
	logic               pv_p6;
	logic signed [31:0] temp_p6, tf_p6;

	always_ff @(posedge clk) begin
		if (en) begin
			s_p6    <= p_p5 + w1_p5 + w2_p5;
			pv_p6   <= pv_p5;
			temp_p6 <= temp_p5;
			tf_p6   <= tf_p5;
		end
	end

	logic signed [63:0] rs_w;
	logic [63:0]        res_w;

	assign rs_w  = $signed(s_p6) >>> 8;
	assign res_w = rs_w + {{44{p7[15]}}, p7, 4'h0};

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			temperature_centi <= temp_p6;
			fine_temperature  <= tf_p6;
			pressure_q24_8    <= pv_p6 ? res_w[31:0] : 32'h0;
			pressure_valid    <= pv_p6;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_s6     <= 1'b0;
			vld_s7     <= 1'b0;
			vld_s8     <= 1'b0;
			vld_s9     <= 1'b0;
			vld_s10    <= 1'b0;
			vld_s11    <= 1'b0;
			vld_s12    <= 1'b0;
			div_v_s[0] <= 1'b0;
			vld_p1     <= 1'b0;
			vld_p2     <= 1'b0;
			vld_p3     <= 1'b0;
			vld_p4     <= 1'b0;
			vld_p5     <= 1'b0;
			vld_p6     <= 1'b0;
			out_valid  <= 1'b0;
		end else if (en) begin
			vld_s1     <= in_valid;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_s4;
			vld_s6     <= vld_s5;
			vld_s7     <= vld_s6;
			vld_s8     <= vld_s7;
			vld_s9     <= vld_s8;
			vld_s10    <= vld_s9;
			vld_s11    <= vld_s10;
			vld_s12    <= vld_s11;
			div_v_s[0] <= vld_s12;
			vld_p1     <= div_v_s[barc_pkg::DIV_STEPS];
			vld_p2     <= vld_p1;
			vld_p3     <= vld_p2;
			vld_p4     <= vld_p3;
			vld_p5     <= vld_p4;
			vld_p6     <= vld_p5;
			out_valid  <= vld_p6;
		end
	end

	// ---------------- assertions ----------------
	a_zero_div_zero_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pressure_valid |-> pressure_q24_8 == 32'h0)
		else $error("pressure not cleared on zero divisor");

	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output held");

	a_stall_only_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output hold");

	a_output_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_p6))
		else $error("output beat without a beat in the last stage");

endmodule

`default_nettype wire
